[hdl/piecewise_linear_interpolator_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise linear interpolator
// Shared macros for the checker that watches the top level ports.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define PLI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/pli_pkg.sv]
// ----------------------------------------------------------------------------
// pli_pkg
// Types and constants of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int DATA_W = 32;
	localparam int SEG_W  = 4;
	localparam int CNT_W  = 5;
	localparam int QUO_W  = 33;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	localparam logic [CNT_W-1:0] COUNT_RESET = 5'd2;

	typedef struct packed {
		logic [DATA_W-1:0] y1;
		logic [SEG_W-1:0]  seg;
		logic              neg;
		logic              dz;
		logic              big;
	} side_t;

endpackage

[hdl/piecewise_linear_interpolator.sv]
// Pipeline order: query register, search and table read, magnitudes, multiply,
//   divider load, 33 divider steps, output register.
// Throughput: one word per cycle; the whole pipeline holds while a result is stalled.
// Reset: arst_n clears valid bits and sets point_count to 2; the table is
//   undefined until written.
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table with segment search and a pipelined restoring divider.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator #(
	parameter int MAX_POINTS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic                              operation,
	input  logic [3:0]                        point_index,
	input  logic signed [pli_pkg::DATA_W-1:0] x_value,
	input  logic signed [pli_pkg::DATA_W-1:0] y_value,
	input  logic                              cfg_wr_en,
	input  logic [pli_pkg::CNT_W-1:0]         cfg_wr_data,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic signed [pli_pkg::DATA_W-1:0] result_y,
	output logic [pli_pkg::SEG_W-1:0]         segment,
	output logic                              divide_by_zero,
	output logic                              saturated
);

	localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
	localparam int STEPS = pli_pkg::QUO_W;

	logic adv;
	logic accept;
	logic [pli_pkg::CNT_W-1:0] pc_q;
	logic signed [31:0] tab_x_q [MAX_POINTS];
	logic signed [31:0] tab_y_q [MAX_POINTS];

	assign adv        = !result_valid || result_ready;
	assign item_ready = adv;
	assign accept     = item_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= pli_pkg::COUNT_RESET;
		end else if (cfg_wr_en) begin
			pc_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && operation == pli_pkg::OP_WRITE && int'(point_index) < MAX_POINTS) begin
			tab_x_q[IDX_W'(point_index)] <= x_value;
			tab_y_q[IDX_W'(point_index)] <= y_value;
		end
	end

	// stage 1: query
	logic v_s1;
	logic signed [31:0] q_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid && operation == pli_pkg::OP_EVAL;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s1 <= x_value;
		end
	end

	logic asc;
	logic [MAX_POINTS-1:0] cmp;
	logic [IDX_W-1:0] last;
	logic [IDX_W-1:0] seg;
	logic [IDX_W-1:0] seg_hi;

	always_comb begin
		asc = tab_x_q[1] > tab_x_q[0];
		for (int i = 0; i < MAX_POINTS; i++) begin
			cmp[i] = asc ? (tab_x_q[i] <= q_s1) : (tab_x_q[i] >= q_s1);
		end
		if (pc_q < pli_pkg::CNT_W'(2)) begin
			last = IDX_W'(1);
		end else if (int'(pc_q) > MAX_POINTS) begin
			last = IDX_W'(MAX_POINTS - 1);
		end else begin
			last = IDX_W'(pc_q - pli_pkg::CNT_W'(1));
		end
		seg = cmp[last] ? IDX_W'(last - IDX_W'(1)) : '0;
		for (int i = MAX_POINTS - 2; i >= 0; i--) begin
			if (IDX_W'(i) < last && cmp[i] && !cmp[i+1]) begin
				seg = IDX_W'(i);
			end
		end
		seg_hi = IDX_W'(seg + IDX_W'(1));
	end

	// stage 2: segment endpoints
	logic v_s2;
	logic signed [31:0] x1_s2, x2_s2, y1_s2, y2_s2, q_s2;
	logic [IDX_W-1:0] seg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s2  <= tab_x_q[seg];
			x2_s2  <= tab_x_q[seg_hi];
			y1_s2  <= tab_y_q[seg];
			y2_s2  <= tab_y_q[seg_hi];
			q_s2   <= q_s1;
			seg_s2 <= seg;
		end
	end

	logic signed [32:0] dx, dy, dq;
	logic [31:0] mdx, mdy, mdq;

	always_comb begin
		dx  = {x2_s2[31], x2_s2} - {x1_s2[31], x1_s2};
		dy  = {y2_s2[31], y2_s2} - {y1_s2[31], y1_s2};
		dq  = {q_s2[31], q_s2} - {x1_s2[31], x1_s2};
		mdx = dx[32] ? 32'(-dx) : dx[31:0];
		mdy = dy[32] ? 32'(-dy) : dy[31:0];
		mdq = dq[32] ? 32'(-dq) : dq[31:0];
	end

	// stage 3: magnitudes
	logic v_s3;
	logic [31:0] mdx_s3, mdy_s3, mdq_s3;
	pli_pkg::side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mdx_s3      <= mdx;
			mdy_s3      <= mdy;
			mdq_s3      <= mdq;
			side_s3.y1  <= y1_s2;
			side_s3.seg <= pli_pkg::SEG_W'(seg_s2);
			side_s3.neg <= (dy[32] ^ dq[32]) ^ dx[32];
			side_s3.dz  <= dx == '0;
			side_s3.big <= 1'b0;
		end
	end

	// stage 4: product
	logic v_s4;
	logic [63:0] prod_s4;
	logic [31:0] mdx_s4;
	pli_pkg::side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s4 <= 64'(mdq_s3) * 64'(mdy_s3);
			mdx_s4  <= mdx_s3;
			side_s4 <= side_s3;
		end
	end

	// divider: one quotient bit per stage
	logic                 dv_v_s   [STEPS+1];
	logic [31:0]          dv_rem_s [STEPS+1];
	logic [32:0]          dv_lo_s  [STEPS+1];
	logic [STEPS-1:0]     dv_quo_s [STEPS+1];
	logic [31:0]          dv_d_s   [STEPS+1];
	pli_pkg::side_t       dv_side_s[STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (adv) begin
			dv_v_s[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_rem_s[0]  <= {1'b0, prod_s4[63:33]};
			dv_lo_s[0]   <= prod_s4[32:0];
			dv_quo_s[0]  <= '0;
			dv_d_s[0]    <= mdx_s4;
			dv_side_s[0] <= '{y1: side_s4.y1, seg: side_s4.seg, neg: side_s4.neg,
				dz: side_s4.dz, big: ({1'b0, prod_s4[63:33]} >= mdx_s4)};
		end
	end

	for (genvar j = 0; j < STEPS; j++) begin : g_div
		logic [32:0] trial;
		logic        ge;

		assign trial = {dv_rem_s[j], dv_lo_s[j][32]};
		assign ge    = trial >= {1'b0, dv_d_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (adv) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s[j+1]  <= ge ? 32'(trial - {1'b0, dv_d_s[j]}) : trial[31:0];
				dv_lo_s[j+1]   <= {dv_lo_s[j][31:0], 1'b0};
				dv_quo_s[j+1]  <= {dv_quo_s[j][STEPS-2:0], ge};
				dv_d_s[j+1]    <= dv_d_s[j];
				dv_side_s[j+1] <= dv_side_s[j];
			end
		end
	end

	// output stage
	pli_pkg::side_t fs;
	logic [STEPS-1:0] quo;
	logic signed [34:0] sum;
	logic [31:0] res;
	logic sat;

	always_comb begin
		fs  = dv_side_s[STEPS];
		quo = dv_quo_s[STEPS];
		sum = fs.neg ? ({{3{fs.y1[31]}}, fs.y1} - {2'b00, quo})
		             : ({{3{fs.y1[31]}}, fs.y1} + {2'b00, quo});
		sat = 1'b0;
		res = fs.y1;
		if (!fs.dz) begin
			if (fs.big || quo > {1'b1, 32'h0000_0000}) begin
				sat = 1'b1;
				res = fs.neg ? 32'h8000_0000 : 32'h7fff_ffff;
			end else if (sum[34:31] != 4'b0000 && sum[34:31] != 4'b1111) begin
				sat = 1'b1;
				res = sum[34] ? 32'h8000_0000 : 32'h7fff_ffff;
			end else begin
				res = sum[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= dv_v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_y       <= res;
			segment        <= fs.seg;
			divide_by_zero <= fs.dz;
			saturated      <= sat;
		end
	end

endmodule

[hdl/pli_chk.sv]
// ----------------------------------------------------------------------------
// pli_chk
// Port checker for the piecewise linear interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`include "piecewise_linear_interpolator_defines.svh"

module pli_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              item_ready,
	input logic                              result_valid,
	input logic                              result_ready,
	input logic signed [pli_pkg::DATA_W-1:0] result_y,
	input logic [pli_pkg::SEG_W-1:0]         segment,
	input logic                              divide_by_zero,
	input logic                              saturated
);

	`PLI_ASSERT_NEXT(a_hold_valid, result_valid && !result_ready, result_valid, "result dropped")
	`PLI_ASSERT_NEXT(a_hold_word, result_valid && !result_ready, $stable(result_y) && $stable(segment), "stalled word changed")
	`PLI_ASSERT_NOW(a_dz_nosat, result_valid && divide_by_zero, !saturated, "saturated with equal endpoints")
	`PLI_ASSERT_NOW(a_sat_rail, result_valid && saturated, result_y == 32'sh7fff_ffff || result_y == -32'sh8000_0000, "saturated value off rail")
	`PLI_ASSERT_NOW(a_stall, result_valid && !result_ready, !item_ready, "input taken while output stalled")

endmodule

bind piecewise_linear_interpolator pli_chk u_pli_chk (.*);

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear interpolator testbench
// Loads breakpoint tables, sweeps the point count and checks every evaluated
// word against a local predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct {
		logic                       op;
		logic [3:0]                 idx;
		logic [pli_pkg::DATA_W-1:0] xv;
		logic [pli_pkg::DATA_W-1:0] yv;
		int                         cfg;
	} word_t;

	typedef struct {
		logic [pli_pkg::DATA_W-1:0] y;
		logic [pli_pkg::SEG_W-1:0]  seg;
		logic                       dz;
		logic                       sat;
	} interp_t;

	logic clk = 0;
	logic arst_n = 0;
	logic item_valid = 0;
	logic item_ready;
	logic operation = 0;
	logic [3:0] point_index = 0;
	logic signed [pli_pkg::DATA_W-1:0] x_value = 0;
	logic signed [pli_pkg::DATA_W-1:0] y_value = 0;
	logic cfg_wr_en = 0;
	logic [pli_pkg::CNT_W-1:0] cfg_wr_data = 0;
	logic result_valid;
	logic result_ready = 0;
	logic signed [pli_pkg::DATA_W-1:0] result_y;
	logic [pli_pkg::SEG_W-1:0] segment;
	logic divide_by_zero;
	logic saturated;

	piecewise_linear_interpolator u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.operation(operation), .point_index(point_index),
		.x_value(x_value), .y_value(y_value),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.result_valid(result_valid), .result_ready(result_ready),
		.result_y(result_y), .segment(segment),
		.divide_by_zero(divide_by_zero), .saturated(saturated)
	);

	word_t   pending_words[$];
	interp_t expected_interp[$];
	longint  table_x[16];
	longint  table_y[16];
	int      active_count = 2;
	int      errors = 0;
	int      send_idle = 0;
	int      recv_idle = 0;
	int      hold_cycles = 0;
	bit      cfg_fire = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic interp_t interpolate(longint q);
		interp_t r;
		int n, last, seg;
		bit found;
		longint x1, x2, y1, y2, dx, dy, dq, res;
		logic [63:0] quot;
		bit neg;
		n = active_count < 2 ? 2 : (active_count > 16 ? 16 : active_count);
		last = n - 1;
		found = 0;
		seg = 0;
		for (int i = 0; i < last; i++) begin
			if (!found && ((table_x[1] > table_x[0]) ?
					(table_x[i] <= q && q < table_x[i+1]) :
					(table_x[i] >= q && q > table_x[i+1]))) begin
				seg = i;
				found = 1;
			end
		end
		if (!found)
			seg = ((table_x[1] > table_x[0]) ? (q >= table_x[last]) : (q <= table_x[last]))
				? last - 1 : 0;
		x1 = table_x[seg]; x2 = table_x[seg+1];
		y1 = table_y[seg]; y2 = table_y[seg+1];
		dx = x2 - x1;
		r.dz = 0; r.sat = 0;
		if (dx == 0) begin
			r.dz = 1;
			res = y1;
		end else begin
			dy = y2 - y1;
			dq = q - x1;
			neg = ((dy < 0) != (dq < 0)) != (dx < 0);
			quot = ($unsigned(dq < 0 ? -dq : dq) * $unsigned(dy < 0 ? -dy : dy)) /
				$unsigned(dx < 0 ? -dx : dx);
			if (quot > 64'h1_0000_0000) begin
				r.sat = 1;
				res = neg ? -64'sd2147483648 : 64'sd2147483647;
			end else begin
				res = neg ? y1 - longint'(quot) : y1 + longint'(quot);
				if (res > 64'sd2147483647) begin
					res = 64'sd2147483647; r.sat = 1;
				end else if (res < -64'sd2147483648) begin
					res = -64'sd2147483648; r.sat = 1;
				end
			end
		end
		r.y = res[31:0];
		r.seg = seg[3:0];
		return r;
	endfunction

	function automatic word_t make_write(int idx, logic [31:0] xv, logic [31:0] yv);
		word_t w;
		w.op = pli_pkg::OP_WRITE; w.idx = idx[3:0]; w.xv = xv; w.yv = yv; w.cfg = -1;
		return w;
	endfunction

	function automatic word_t make_eval(logic [31:0] xv);
		word_t w;
		w.op = pli_pkg::OP_EVAL; w.idx = 4'($urandom); w.xv = xv; w.yv = $urandom;
		w.cfg = -1;
		return w;
	endfunction

	function automatic word_t make_cfg(int cnt);
		word_t w;
		w.op = pli_pkg::OP_WRITE; w.idx = '0; w.xv = '0; w.yv = '0; w.cfg = cnt;
		return w;
	endfunction

	function automatic logic [31:0] rand_data();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 255) - 128;
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			cfg_fire = 0;
			if (item_valid && item_ready) begin
				if (operation == pli_pkg::OP_WRITE) begin
					table_x[point_index] = longint'(x_value);
					table_y[point_index] = longint'(y_value);
				end else begin
					expected_interp.push_back(interpolate(longint'(x_value)));
				end
			end
			if (!(item_valid && !item_ready)) begin
				if (pending_words.size() > 0 && pending_words[0].cfg >= 0) begin
					item_valid <= 0;
					if (expected_interp.size() == 0 && !(item_valid && item_ready)
							&& hold_cycles >= 45) begin
						cfg_fire = 1;
						cfg_wr_data <= pending_words[0].cfg[4:0];
						active_count = pending_words[0].cfg;
						void'(pending_words.pop_front());
						hold_cycles <= 0;
					end else if (expected_interp.size() == 0 && !(item_valid && item_ready))
						hold_cycles <= hold_cycles + 1;
					else
						hold_cycles <= 0;
				end else if (pending_words.size() > 0 &&
						$urandom_range(0, 99) >= send_idle) begin
					word_t w;
					w = pending_words.pop_front();
					item_valid <= 1;
					operation <= w.op;
					point_index <= w.idx;
					x_value <= w.xv;
					y_value <= w.yv;
				end else begin
					item_valid <= 0;
				end
			end
			cfg_wr_en <= cfg_fire;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_interp.size() == 0) begin
					report_mismatch("unexpected word", result_y, 0);
				end else begin
					interp_t e;
					e = expected_interp.pop_front();
					if (result_y !== e.y) report_mismatch("result_y", result_y, e.y);
					if (segment !== e.seg) report_mismatch("segment", segment, e.seg);
					if (divide_by_zero !== e.dz)
						report_mismatch("divide_by_zero", divide_by_zero, e.dz);
					if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
				end
			end
			result_ready <= $urandom_range(0, 99) >= recv_idle;
		end
	end

	task automatic load_table(int n, bit ascending, bit dup);
		longint xv;
		xv = $signed($urandom_range(0, 2000)) - 1000;
		if (!ascending) xv = -xv;
		for (int i = 0; i < 16; i++) begin
			pending_words.push_back(make_write(i, xv[31:0], rand_data()));
			if (!(dup && $urandom_range(0, 3) == 0)) begin
				if ($urandom_range(0, 9) == 0)
					xv = ascending ? xv + $urandom_range(1, 32'h0800_0000) :
						xv - $urandom_range(1, 32'h0800_0000);
				else
					xv = ascending ? xv + $urandom_range(1, 4096) :
						xv - $urandom_range(1, 4096);
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_words.size() > 0 || item_valid || expected_interp.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int counts[6] = '{2, 16, 0, 31, 5, 9};
		for (int i = 0; i < 16; i++) begin
			table_x[i] = 0; table_y[i] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1;
		// directed: extremes, equal endpoints, saturation, both directions
		pending_words.push_back(make_write(0, 32'h8000_0000, 32'h8000_0000));
		pending_words.push_back(make_write(1, 32'h7fff_ffff, 32'h7fff_ffff));
		pending_words.push_back(make_eval(32'h8000_0000));
		pending_words.push_back(make_eval(32'h7fff_ffff));
		pending_words.push_back(make_eval(32'h0000_0000));
		pending_words.push_back(make_write(1, 32'h8000_0001, 32'h7fff_ffff));
		pending_words.push_back(make_eval(32'h7fff_ffff));
		pending_words.push_back(make_eval(32'hffff_ffff));
		pending_words.push_back(make_write(1, 32'h8000_0000, 32'h1234_5678));
		pending_words.push_back(make_eval(32'h0000_0001));
		pending_words.push_back(make_write(0, 32'h0001_0000, 32'h0000_0000));
		pending_words.push_back(make_write(1, 32'h0000_0000, 32'h7fff_ffff));
		pending_words.push_back(make_eval(32'h8000_0000));
		pending_words.push_back(make_eval(32'h7fff_ffff));
		pending_words.push_back(make_eval(32'h0000_8000));
		pending_words.push_back(make_write(0, 32'h0000_0000, 32'h8000_0000));
		pending_words.push_back(make_write(1, 32'h0000_0001, 32'h7fff_ffff));
		pending_words.push_back(make_eval(32'h7fff_ffff));
		pending_words.push_back(make_eval(32'h8000_0000));
		wait_drained();
		for (int ph = 0; ph < 24; ph++) begin
			send_idle = (ph % 4 == 1 || ph % 4 == 3) ? 83 : 0;
			recv_idle = (ph % 4 == 2) ? 83 : (ph % 4 == 3 ? 19 : 0);
			if (ph % 4 == 3) send_idle = 19;
			load_table(16, $urandom_range(0, 1), ph % 3 == 2);
			pending_words.push_back(make_cfg(counts[ph % 6]));
			for (int k = 0; k < 46; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					pending_words.push_back(make_write($urandom_range(2, 15), rand_data(),
						rand_data()));
				end else if ($urandom_range(0, 3) == 0)
					pending_words.push_back(make_eval(rand_data()));
				else
					pending_words.push_back(make_eval($urandom_range(0, 70000) - 3000));
			end
			if (ph == 5) begin
				recv_idle = 100;
				repeat (300) @(posedge clk);
				recv_idle = 0;
			end
			wait_drained();
		end
		repeat (60) @(posedge clk);
		if (errors == 0 && expected_interp.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end
endmodule

[filelist.f]
+incdir+hdl
hdl/pli_pkg.sv
hdl/piecewise_linear_interpolator.sv
hdl/pli_chk.sv
sim/testbench.sv
